// ===== rtl/lcrc_pkg.sv =====
package lcrc_pkg;

  localparam int unsigned MAX_SAMPLES_DEF  = 2048;
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_ENTRIES     = 24;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_MM        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_MIN_MM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LATERAL_MAX_MM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_THRESHOLD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_ENABLE   = 3'd6;

  localparam logic [15:0] CLAMP_MM_RST        = 16'd5000;
  localparam logic [15:0] FORWARD_MIN_MM_RST  = 16'd1500;
  localparam logic [15:0] LATERAL_MAX_MM_RST  = 16'd4000;
  localparam logic [11:0] COUNT_THRESHOLD_RST = 12'd40;

  // 1/K of the cordic gain in Q30
  localparam logic [29:0] KINV_Q30 = 30'h26DD3B6A;

  // x and y in mm Q16 plus headroom for the cordic gain and sign
  localparam int unsigned COORD_W = 35;
  localparam int unsigned ZACC_W  = 34;

  typedef struct packed {
    logic [15:0] angle_start;
    logic [15:0] angle_step;
    logic [15:0] clamp_mm;
    logic [15:0] forward_min_mm;
    logic [15:0] lateral_max_mm;
    logic [11:0] count_threshold;
    logic        detect_enable;
  } lcrc_cfg_t;

  typedef struct packed {
    logic [15:0] range_mm;
    logic [15:0] out_range_mm;
    logic [15:0] angle;
    logic        countable;
    logic        last;
  } lcrc_item_t;

  // atan(2^-i) in 2^32 units per turn
  function automatic logic [31:0] atan_at(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/lcrc_front.sv =====
module lcrc_front import lcrc_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lcrc_cfg_t  cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [15:0] range_mm_i,
  input  logic       range_invalid_i,
  input  logic       last_sample_i,
  input  logic       full_i,
  output logic       push_o,
  output lcrc_item_t item_o
);

  localparam int unsigned IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W+15:0] offset;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // index times step, only the low 16 bits matter (angle wraps each turn)
  assign offset = {16'b0, idx_q} * {{IDX_W{1'b0}}, cfg_i.angle_step};

  always_comb begin
    item_o.range_mm     = range_mm_i;
    item_o.out_range_mm = (range_invalid_i || (range_mm_i > cfg_i.clamp_mm)) ?
                          cfg_i.clamp_mm : range_mm_i;
    item_o.angle        = cfg_i.angle_start + offset[15:0];
    item_o.countable    = cfg_i.detect_enable && !range_invalid_i;
    item_o.last         = last_sample_i;
  end

  always_comb begin
    idx_d = idx_q;
    if (push_o) begin
      if (last_sample_i) begin
        idx_d = '0;
      end else if (idx_q < IDX_LAST) begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== rtl/lcrc_queue.sv =====
module lcrc_queue import lcrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  lcrc_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output lcrc_item_t item_o,
  output logic       empty_o
);

  lcrc_item_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/lcrc_back.sv =====
module lcrc_back import lcrc_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lcrc_cfg_t   cfg_i,
  input  logic        empty_i,
  input  lcrc_item_t  item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_range_mm_o,
  output logic        scan_end_o,
  output logic        door_open_o
);

  localparam int unsigned NSTEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int unsigned IT_W   = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(NSTEPS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_ITER = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                state_q, state_d;
  lcrc_item_t                cur_q, cur_d;
  logic signed [COORD_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZACC_W-1:0]  z_q, z_d;
  logic [IT_W-1:0]           iter_q, iter_d;
  logic [11:0]               cnt_q, cnt_d;
  logic                      out_valid_q, out_valid_d;
  logic [15:0]               out_range_q, out_range_d;
  logic                      scan_end_q, scan_end_d;
  logic                      door_open_q, door_open_d;

  logic [45:0]               prod;
  logic signed [COORD_W-1:0] x0, xs, ys, y_abs, fwd_lim, lat_lim;
  logic signed [ZACC_W-1:0]  atan_s;
  logic                      fold, hit, out_free;
  logic [15:0]               ang_f;
  logic [11:0]               cnt_inc;

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;

  assign prod = 46'(cur_q.range_mm) * 46'(KINV_Q30);
  assign x0   = $signed({3'b000, prod[45:14]});

  // angles beyond +-90 degrees: rotate by half a turn and start from -x
  assign fold  = cur_q.angle[15] ^ cur_q.angle[14];
  assign ang_f = {cur_q.angle[15] ^ fold, cur_q.angle[14:0]};

  assign xs     = x_q >>> iter_q;
  assign ys     = y_q >>> iter_q;
  assign atan_s = $signed({2'b00, atan_at(5'(iter_q))});

  assign y_abs   = y_q[COORD_W-1] ? -y_q : y_q;
  assign fwd_lim = $signed({3'b000, cfg_i.forward_min_mm, 16'b0});
  assign lat_lim = $signed({3'b000, cfg_i.lateral_max_mm, 16'b0});
  assign hit     = cur_q.countable && (x_q > fwd_lim) && (y_abs < lat_lim);
  assign cnt_inc = (hit && (cnt_q != 12'hFFF)) ? cnt_q + 12'd1 : cnt_q;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    iter_d      = iter_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_range_d = out_range_q;
    scan_end_d  = scan_end_q;
    door_open_d = door_open_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          cur_d   = item_i;
          // samples that cannot count skip the rotation
          state_d = item_i.countable ? ST_LOAD : ST_DONE;
        end
      end
      ST_LOAD: begin
        x_d     = fold ? -x0 : x0;
        y_d     = '0;
        z_d     = {{2{ang_f[15]}}, ang_f, 16'b0};
        iter_d  = '0;
        state_d = ST_ITER;
      end
      ST_ITER: begin
        if (!z_q[ZACC_W-1]) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - atan_s;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + atan_s;
        end
        iter_d = iter_q + 1'b1;
        if (iter_q == IT_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_range_d = cur_q.out_range_mm;
          scan_end_d  = cur_q.last;
          door_open_d = cur_q.last && cfg_i.detect_enable &&
                        (cnt_inc > cfg_i.count_threshold);
          cnt_d       = cur_q.last ? 12'd0 : cnt_inc;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 12'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    x_q         <= x_d;
    y_q         <= y_d;
    z_q         <= z_d;
    iter_q      <= iter_d;
    out_range_q <= out_range_d;
    scan_end_q  <= scan_end_d;
    door_open_q <= door_open_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_range_mm_o = out_range_q;
  assign scan_end_o     = scan_end_q;
  assign door_open_o    = door_open_q;

endmodule

// ===== rtl/lidar_clamp_and_region_count_core.sv =====
// Laser scan range clamp and forward-region point counter.
// Input channel (in_valid_i/in_ready_o): one range sample per transaction, in mm,
// with an invalid flag and a last-of-scan flag. Output channel (out_valid_o/
// out_ready_i): one transaction per sample, carrying the clamped range, scan_end
// and, on the last sample, door_open.
// The front side clamps the range, tracks the sample index and forms the beam
// angle, then pushes the sample into a two-entry queue. The back side rotates
// the range vector with an iterative CORDIC (one step per cycle) and counts
// points inside the forward region.
// A sample that can be counted passes the back side in order: pop, start-vector
// multiply, rotation steps, region test and output; an invalid sample or one with
// detection off goes from the pop straight to the output. The back side pops the
// next sample only after the current one has been handed to the output register.
// The queue and the output register keep the input open while the receiver
// stalls: up to four samples may be in flight before in_ready_o drops.
// Reset clears the index, the count, the queue and the output valid, and loads
// the register defaults. Config writes through cfg_we_i take effect next cycle.
module lidar_clamp_and_region_count_core import lcrc_pkg::*; #(
  parameter int unsigned MAX_SAMPLES  = MAX_SAMPLES_DEF,
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [15:0]           range_mm_i,
  input  logic                  range_invalid_i,
  input  logic                  last_sample_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [15:0]           out_range_mm_o,
  output logic                  scan_end_o,
  output logic                  door_open_o
);

  lcrc_cfg_t  cfg_q, cfg_d;
  lcrc_item_t push_item, pop_item;
  logic       push, pop, full, empty;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ANGLE_START:     cfg_d.angle_start     = cfg_wdata_i;
        REG_ANGLE_STEP:      cfg_d.angle_step      = cfg_wdata_i;
        REG_CLAMP_MM:        cfg_d.clamp_mm        = cfg_wdata_i;
        REG_FORWARD_MIN_MM:  cfg_d.forward_min_mm  = cfg_wdata_i;
        REG_LATERAL_MAX_MM:  cfg_d.lateral_max_mm  = cfg_wdata_i;
        REG_COUNT_THRESHOLD: cfg_d.count_threshold = cfg_wdata_i[11:0];
        REG_DETECT_ENABLE:   cfg_d.detect_enable   = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_start     <= 16'd0;
      cfg_q.angle_step      <= 16'd0;
      cfg_q.clamp_mm        <= CLAMP_MM_RST;
      cfg_q.forward_min_mm  <= FORWARD_MIN_MM_RST;
      cfg_q.lateral_max_mm  <= LATERAL_MAX_MM_RST;
      cfg_q.count_threshold <= COUNT_THRESHOLD_RST;
      cfg_q.detect_enable   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lcrc_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .range_mm_i      (range_mm_i),
    .range_invalid_i (range_invalid_i),
    .last_sample_i   (last_sample_i),
    .full_i          (full),
    .push_o          (push),
    .item_o          (push_item)
  );

  lcrc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (empty)
  );

  lcrc_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .empty_i        (empty),
    .item_i         (pop_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_range_mm_o (out_range_mm_o),
    .scan_end_o     (scan_end_o),
    .door_open_o    (door_open_o)
  );

endmodule

// ===== rtl/lcrc_checker.sv =====
module lcrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] out_range_mm_o,
  input logic        scan_end_o,
  input logic        door_open_o
);

  logic [2:0] pend_q, pend_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // samples accepted but not yet delivered
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_range_mm_o) &&
    $stable(scan_end_o) && $stable(door_open_o))
    else $error("output changed while stalled");

  a_open_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && door_open_o |-> scan_end_o)
    else $error("door_open without scan_end");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != 3'd0)
    else $error("result without an accepted sample");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd4)
    else $error("more samples in flight than storage");

endmodule

bind lidar_clamp_and_region_count_core lcrc_checker u_lcrc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_range_mm_o (out_range_mm_o),
  .scan_end_o     (scan_end_o),
  .door_open_o    (door_open_o)
);
